@@ src/lsa_pkg.sv @@
// Shared constants and types for the LIFO stack allocator.
package lsa_pkg;

  // Field widths
  localparam int ADDR_W   = 32;  // byte address width, arithmetic wraps at this width
  localparam int OFF_W    = 21;  // arena offset and size width
  localparam int PAD_W    = 8;   // stored padding width
  localparam int ALIGN_W  = 3;   // alignment exponent width
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 3;
  localparam int HDR_W    = OFF_W + PAD_W;  // header entry: start offset and padding
  localparam int CFG_IDX_W = 8;

  // Stream word layouts
  localparam int IN_DATA_W  = 56;  // size, align, free address
  localparam int OUT_DATA_W = 56;  // status, block address, block size

  // Header room in front of every block, in bytes
  localparam int HEADER_BYTES = 16;

  // Default number of live blocks the header stack holds
  localparam int MAX_LIVE_DEF = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA = CFG_IDX_W'(1);

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_RESET = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_DOUBLE   = 3'd4,
    ST_ORDER    = 3'd5,
    ST_NULL     = 3'd6
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // One result word
  typedef struct packed {
    logic [OFF_W-1:0]  bsize;
    logic [ADDR_W-1:0] baddr;
    status_e           status;
  } result_t;

endpackage

@@ src/lifo_stack_allocator_unit.sv @@
// LIFO arena allocator: stream ports, configuration registers, core and header memory.
// Result path: a request word is captured as the core enters the execute state; the result
// word is registered from there, delayed while the previous result waits for the receiver.
// Requests: a new request word is taken only in the idle state, after the previous one has
// executed, which leaves room for the header memory's registered read of the top entry.
// Reset: offset, live count and registers clear at once; header memory is not cleared,
// entries are only used after they have been written.
module lifo_stack_allocator_unit
  import lsa_pkg::*;
#(
  parameter int MAX_LIVE = MAX_LIVE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [20:0] alloc_size, [23:21] align_log2, [55:24] free_address
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [REQ_W-1:0]      s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] status, [34:3] block_address, [55:35] block_size
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ADDR_W-1:0]     cfg_data_i
);

  localparam int AW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;

  logic [ADDR_W-1:0] base_q;
  logic [OFF_W-1:0]  arena_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [HDR_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [HDR_W-1:0]  ram_rdata;
  result_t           res;

  // Configuration registers, writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      arena_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BASE:  base_q  <= cfg_data_i;
        CFG_ARENA: arena_q <= cfg_data_i[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  lsa_core #(
    .MAX_LIVE (MAX_LIVE)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .base_i         (base_q),
    .arena_i        (arena_q),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .req_type_i     (s_axis_tuser),
    .alloc_size_i   (s_axis_tdata[20:0]),
    .align_log2_i   (s_axis_tdata[23:21]),
    .free_address_i (s_axis_tdata[55:24]),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_o          (res),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  lsa_ram #(
    .WIDTH (HDR_W),
    .DEPTH (MAX_LIVE)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result word packing
  assign m_axis_tdata = res;

endmodule

@@ src/lsa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lsa_ram
  import lsa_pkg::*;
#(
  parameter int WIDTH = HDR_W,
  parameter int DEPTH = MAX_LIVE_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lsa_core.sv @@
// Request sequencer: offset and live count, header stack access, result register.
module lsa_core
  import lsa_pkg::*;
#(
  parameter int MAX_LIVE = MAX_LIVE_DEF,
  localparam int AW      = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1,
  localparam int CNT_W   = $clog2(MAX_LIVE + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic [ADDR_W-1:0]  base_i,
  input  logic [OFF_W-1:0]   arena_i,
  // request side
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [OFF_W-1:0]   alloc_size_i,
  input  logic [ALIGN_W-1:0] align_log2_i,
  input  logic [ADDR_W-1:0]  free_address_i,
  // result side
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output result_t            res_o,
  // header stack memory
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [HDR_W-1:0]   ram_wdata_o,
  output logic [AW-1:0]      ram_raddr_o,
  input  logic [HDR_W-1:0]   ram_rdata_i
);

  state_e state_q, state_d;

  logic [OFF_W-1:0]  off_q, off_d;
  logic [CNT_W-1:0]  live_q, live_d;

  // request captured at accept, with address work done up front
  logic [REQ_W-1:0]  req_q;
  logic [OFF_W-1:0]  size_q;
  logic [ADDR_W-1:0] cur_q;
  logic [PAD_W-1:0]  pad_q;
  logic [ADDR_W-1:0] rel_q;
  logic              null_q;

  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;

  // accept-cycle address arithmetic
  logic [ADDR_W-1:0] cur_w;
  logic [6:0]        amask_w;
  logic [PAD_W-1:0]  p0_w;
  logic [8:0]        gap_w;
  logic [8:0]        round_w;
  logic [8:0]        pad9_w;
  logic [PAD_W-1:0]  pad_w;

  // execute-cycle checks
  logic [OFF_W+1:0]  need_w;
  logic              no_space_w;
  logic              full_w;
  logic [OFF_W-1:0]  top_start_w;
  logic [PAD_W-1:0]  top_pad_w;
  logic [OFF_W:0]    top_addr_w;
  logic              out_free_w;
  logic              accept_w;

  assign accept_w   = req_valid_i && (state_q == S_IDLE);
  assign out_free_w = !res_valid_q || res_ready_i;

  // Padding: smallest p >= header room with (cur + p) aligned
  always_comb begin
    cur_w   = base_i + ADDR_W'(off_q);
    amask_w = ~(7'h7F << align_log2_i);
    p0_w    = {1'b0, (~cur_w[6:0] + 7'd1) & amask_w};
    gap_w   = 9'(HEADER_BYTES) - {1'b0, p0_w};
    round_w = (gap_w + {2'b0, amask_w}) & ~{2'b0, amask_w};
    if (p0_w < PAD_W'(HEADER_BYTES)) begin
      pad9_w = {1'b0, p0_w} + round_w;
    end else begin
      pad9_w = {1'b0, p0_w};
    end
    pad_w = pad9_w[PAD_W-1:0];
  end

  // Capture the request word
  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      req_q  <= req_type_i;
      size_q <= alloc_size_i;
      cur_q  <= cur_w;
      pad_q  <= pad_w;
      rel_q  <= free_address_i - base_i;
      null_q <= (free_address_i == '0);
    end
  end

  // Header stack: top entry is always being read
  assign ram_raddr_o = AW'(live_q - CNT_W'(1));
  assign top_start_w = ram_rdata_i[HDR_W-1:PAD_W];
  assign top_pad_w   = ram_rdata_i[PAD_W-1:0];
  assign top_addr_w  = {1'b0, top_start_w} + (OFF_W+1)'(top_pad_w);

  assign need_w     = (OFF_W+2)'(off_q) + (OFF_W+2)'(pad_q) + (OFF_W+2)'(size_q);
  assign no_space_w = need_w > (OFF_W+2)'(arena_i);
  assign full_w     = live_q >= CNT_W'(MAX_LIVE);

  // Next state and execute
  always_comb begin
    state_d     = state_q;
    off_d       = off_q;
    live_d      = live_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = live_q[AW-1:0];
    ram_wdata_o = {off_q, pad_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free_w) begin
          state_d      = S_IDLE;
          res_valid_d  = 1'b1;
          res_d.status = ST_OK;
          res_d.baddr  = '0;
          res_d.bsize  = '0;
          unique case (req_q)
            REQ_ALLOC: begin
              if (no_space_w) begin
                res_d.status = ST_NO_SPACE;
              end else if (full_w) begin
                res_d.status = ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                live_d      = live_q + CNT_W'(1);
                off_d       = need_w[OFF_W-1:0];
                res_d.baddr = cur_q + ADDR_W'(pad_q);
                res_d.bsize = size_q;
              end
            end
            REQ_FREE: begin
              if (null_q) begin
                res_d.status = ST_NULL;
              end else if (rel_q >= ADDR_W'(arena_i)) begin
                res_d.status = ST_RANGE;
              end else if (rel_q >= ADDR_W'(off_q)) begin
                res_d.status = ST_DOUBLE;
              end else if (live_q == '0) begin
                res_d.status = ST_ORDER;
              end else if (rel_q != ADDR_W'(top_addr_w)) begin
                res_d.status = ST_ORDER;
              end else begin
                live_d = live_q - CNT_W'(1);
                off_d  = top_start_w;
              end
            end
            REQ_RESET: begin
              live_d = '0;
              off_d  = '0;
            end
            default: begin
              // unused request code: no effect
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      off_q       <= '0;
      live_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      off_q       <= off_d;
      live_q      <= live_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
